// ----- sv/pst_pkg.sv -----
// Package for the per-source sequence tracker.
// Holds table sizing, result status codes, register indexes and the shared types.
// No dependencies.
package pst_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam int SEQ_W  = 16;
   localparam int CNT_W  = 32;
   localparam int ADDR_W = 16;
   localparam int OUT_IDX_W = 5;

   // Result status codes
   localparam logic [2:0] STATUS_FIRST   = 3'd0;
   localparam logic [2:0] STATUS_INORDER = 3'd1;
   localparam logic [2:0] STATUS_GAP     = 3'd2;
   localparam logic [2:0] STATUS_DUP     = 3'd3;
   localparam logic [2:0] STATUS_FULL    = 3'd4;

   // Register indexes on the csr port
   localparam logic [1:0] REG_MIN_RECEIVED = 2'd0;
   localparam logic [1:0] REG_LOW_SEQ      = 2'd1;
   localparam logic [1:0] REG_HIGH_LAST    = 2'd2;

   localparam logic [15:0] RST_MIN_RECEIVED = 16'd10;
   localparam logic [15:0] RST_LOW_SEQ      = 16'd3;
   localparam logic [15:0] RST_HIGH_LAST    = 16'd100;

   typedef struct packed {
      logic [CNT_W-1:0] dups;
      logic [CNT_W-1:0] gaps;
      logic [CNT_W-1:0] received;
      logic [SEQ_W-1:0] last;
      logic [SEQ_W-1:0] first;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [15:0] min_received;
      logic [15:0] low_seq;
      logic [15:0] high_last;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_stall;
   } sts_type;

endpackage

// ----- sv/pst_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pst_ctrl.sv -----
// Controller for the sequence tracker: accepts an item, then commits its update.
// Depends on pst_pkg.
module pst_ctrl
   import pst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_UPDATE = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.commit = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // hold while the previous result still waits
            if (!sts.out_stall) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/pst_dp.sv -----
// Datapath for the sequence tracker: source match, entry RAM, update and result register.
// Depends on pst_pkg and pst_ram.
module pst_dp
   import pst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output sts_type       sts,
   input  cfg_type       cfg,
   input  logic [31:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,
   output logic [3:0]    rsp_tuser
);

   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [ADDR_W-1:0]        source_ff [TABLE_ENTRIES];

   logic [ADDR_W-1:0] in_src;
   logic [SEQ_W-1:0]  in_seq;
   logic [TABLE_ENTRIES-1:0] hit_vec;
   logic [IDX_W-1:0]  hit_idx;
   logic [IDX_W-1:0]  free_idx;
   logic              any_hit;
   logic              any_free;
   logic [IDX_W-1:0]  pick_idx;

   logic [SEQ_W-1:0]  seq_ff;
   logic [ADDR_W-1:0] src_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              alloc_ff;
   logic              full_ff;

   entry_type ram_rd;
   entry_type cur;
   entry_type upd;
   logic [2:0] status;
   logic       restarted;
   logic       is_first;
   logic       restart;
   logic [SEQ_W-1:0] last_r;
   logic [SEQ_W-1:0] next_seq;
   logic [SEQ_W-1:0] skipped;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [135:0]       rsp_data_ff;
   logic [3:0]         rsp_user_ff;
   logic [8:0]         idx_wide;

   assign in_src = req_tdata[15:0];
   assign in_seq = req_tdata[31:16];

   // Parallel match against every valid slot; lowest free slot for allocation
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      any_hit  = 1'b0;
      any_free = 1'b0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         hit_vec[i] = valid_ff[i] && (source_ff[i] == in_src);
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
            any_hit = 1'b1;
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
            any_free = 1'b1;
         end
      end
      pick_idx = any_hit ? hit_idx : free_idx;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         seq_ff   <= in_seq;
         src_ff   <= in_src;
         idx_ff   <= pick_idx;
         alloc_ff <= !any_hit;
         full_ff  <= !any_hit && !any_free;
      end
   end

   pst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && !full_ff),
      .wr_addr (idx_ff),
      .wr_data (upd),
      .rd_en   (cmd.accept),
      .rd_addr (pick_idx),
      .rd_data (ram_rd)
   );

   // Entry update
   always_comb begin
      cur       = alloc_ff ? '0 : ram_rd;
      upd       = cur;
      restarted = 1'b0;
      status    = STATUS_DUP;
      is_first  = (cur.received == '0) && (cur.first == '0) && (cur.last == '0);
      restart   = (cur.received > CNT_W'(cfg.min_received)) &&
                  (seq_ff < cfg.low_seq) && (cur.last > cfg.high_last);
      last_r    = restart ? seq_ff : cur.last;
      next_seq  = last_r + SEQ_W'(1);
      skipped   = seq_ff - last_r - SEQ_W'(1);
      if (is_first) begin
         upd.first    = seq_ff;
         upd.last     = seq_ff;
         upd.received = CNT_W'(1);
         status       = STATUS_FIRST;
      end else begin
         if (restart) begin
            upd.first    = seq_ff;
            upd.last     = seq_ff;
            upd.received = '0;
            upd.gaps     = '0;
            upd.dups     = '0;
            restarted    = 1'b1;
         end
         if (seq_ff == next_seq) begin
            upd.received = upd.received + CNT_W'(1);
            upd.last     = seq_ff;
            status       = STATUS_INORDER;
         end else if (seq_ff > next_seq) begin
            upd.gaps     = upd.gaps + CNT_W'(skipped);
            upd.received = upd.received + CNT_W'(1);
            upd.last     = seq_ff;
            status       = STATUS_GAP;
         end else begin
            upd.dups = upd.dups + CNT_W'(1);
            status   = STATUS_DUP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit && !full_ff) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && !full_ff) begin
         source_ff[idx_ff] <= src_ff;
      end
   end

   // Result register
   assign idx_wide     = 9'(idx_ff);
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (full_ff) begin
            rsp_data_ff <= '0;
            rsp_user_ff <= {1'b0, STATUS_FULL};
         end else begin
            rsp_data_ff <= {3'b000, upd.dups, upd.gaps, upd.received,
                            upd.last, upd.first, idx_wide[OUT_IDX_W-1:0]};
            rsp_user_ff <= {restarted, status};
         end
      end
   end

   assign sts.out_stall = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;
   assign rsp_tuser     = rsp_user_ff;

endmodule

// ----- sv/per_source_sequence_tracker.sv -----
// Top level of the per-source sequence tracker: csr registers, controller and datapath.
// Depends on pst_pkg, pst_ctrl and pst_dp.
//
//   Channel   Direction  Handshake           Payload
//   req_      in         tvalid/tready       tdata: source_addr, seq_num
//   rsp_      out        tvalid/tready       tdata: entry and counters, tuser: status
//   csr_      in         psel/penable/pready three 16-bit restart registers
//
// Per item, the accept step matches the source against all slots and reads the entry
// RAM; the update step updates the entry, writes it back and loads the result register.
// Reset clears the slot valid bits and the result valid flag; no clearing pass.
// A waiting result holds the update cycle; the next item is taken once it commits.
module per_source_sequence_tracker
   import pst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // [15:0] source_addr, [31:16] seq_num

   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,   // [4:0] entry_index, [20:5] first sequence,
                                      // [36:21] last sequence, [68:37] received_out,
                                      // [100:69] gaps_out, [132:101] dups_out, zero pad
   output logic [3:0]    rsp_tuser,   // [2:0] status, [3] restarted

   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;
   logic    csr_wr;
   logic [1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_received <= RST_MIN_RECEIVED;
         cfg_ff.low_seq      <= RST_LOW_SEQ;
         cfg_ff.high_last    <= RST_HIGH_LAST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_MIN_RECEIVED: cfg_ff.min_received <= csr_pwdata[15:0];
            REG_LOW_SEQ:      cfg_ff.low_seq      <= csr_pwdata[15:0];
            REG_HIGH_LAST:    cfg_ff.high_last    <= csr_pwdata[15:0];
            default: ;  // drop writes past the last register
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MIN_RECEIVED: csr_prdata = {16'h0000, cfg_ff.min_received};
         REG_LOW_SEQ:      csr_prdata = {16'h0000, cfg_ff.low_seq};
         REG_HIGH_LAST:    csr_prdata = {16'h0000, cfg_ff.high_last};
         default:          csr_prdata = '0;
      endcase
   end

   pst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pst_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .cfg        (cfg_ff),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for per_source_sequence_tracker: packets in on req_, entries out on rsp_.
// A table model in the scoreboard class predicts each entry; csr_ writes move the restart limits.
// Depends on pst_pkg and the per_source_sequence_tracker RTL.
module tb;
   import pst_pkg::*;

   typedef struct {
      logic [2:0]  status;
      logic        restarted;
      logic [4:0]  index;
      logic [15:0] first;
      logic [15:0] last;
      logic [31:0] received;
      logic [31:0] gaps;
      logic [31:0] dups;
   } track_result_type;

   class sequence_tracker_model;
      bit          in_use  [TABLE_ENTRIES];
      logic [15:0] src_of  [TABLE_ENTRIES];
      logic [15:0] first_of[TABLE_ENTRIES];
      logic [15:0] last_of [TABLE_ENTRIES];
      logic [31:0] recv_of [TABLE_ENTRIES];
      logic [31:0] gaps_of [TABLE_ENTRIES];
      logic [31:0] dups_of [TABLE_ENTRIES];
      logic [15:0] min_received = RST_MIN_RECEIVED;
      logic [15:0] low_seq      = RST_LOW_SEQ;
      logic [15:0] high_last    = RST_HIGH_LAST;
      track_result_type expected_entries[$];
      int          mismatches;

      function void set_register(logic [1:0] idx, logic [15:0] value);
         case (idx)
            REG_MIN_RECEIVED: min_received = value;
            REG_LOW_SEQ:      low_seq      = value;
            REG_HIGH_LAST:    high_last    = value;
            default: ;
         endcase
      endfunction

      function void note_packet(logic [15:0] src, logic [15:0] seq);
         track_result_type r;
         int          s;
         int          free_slot;
         logic [15:0] nxt;
         logic [15:0] skipped;
         r = '{status: STATUS_FULL, restarted: 1'b0, index: '0, first: '0, last: '0,
               received: '0, gaps: '0, dups: '0};
         s = -1;
         free_slot = -1;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (s < 0 && in_use[i] && src_of[i] == src) s = i;
            if (!in_use[i] && free_slot < 0) free_slot = i;
         end
         if (s < 0 && free_slot >= 0) begin
            s = free_slot;
            in_use[s]   = 1'b1;
            src_of[s]   = src;
            first_of[s] = '0;
            last_of[s]  = '0;
            recv_of[s]  = '0;
            gaps_of[s]  = '0;
            dups_of[s]  = '0;
         end
         if (s >= 0) begin
            if (recv_of[s] == 0 && first_of[s] == 0 && last_of[s] == 0) begin
               first_of[s] = seq;
               last_of[s]  = seq;
               recv_of[s]  = 32'd1;
               r.status    = STATUS_FIRST;
            end else begin
               if (recv_of[s] > {16'h0000, min_received} && seq < low_seq &&
                   last_of[s] > high_last) begin
                  first_of[s] = seq;
                  last_of[s]  = seq;
                  recv_of[s]  = '0;
                  gaps_of[s]  = '0;
                  dups_of[s]  = '0;
                  r.restarted = 1'b1;
               end
               nxt = last_of[s] + 16'd1;
               if (seq == nxt) begin
                  recv_of[s] += 32'd1;
                  last_of[s]  = seq;
                  r.status    = STATUS_INORDER;
               end else if (seq > nxt) begin
                  skipped     = seq - last_of[s] - 16'd1;
                  gaps_of[s] += {16'h0000, skipped};
                  recv_of[s] += 32'd1;
                  last_of[s]  = seq;
                  r.status    = STATUS_GAP;
               end else begin
                  dups_of[s] += 32'd1;
                  r.status    = STATUS_DUP;
               end
            end
            r.index    = 5'(s);
            r.first    = first_of[s];
            r.last     = last_of[s];
            r.received = recv_of[s];
            r.gaps     = gaps_of[s];
            r.dups     = dups_of[s];
         end
         expected_entries.push_back(r);
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      endtask

      task check_result(logic [135:0] data, logic [3:0] user);
         track_result_type want;
         if (expected_entries.size() == 0) begin
            report_mismatch("result with no packet outstanding");
            return;
         end
         want = expected_entries.pop_front();
         compare_field("status", user[2:0], want.status);
         compare_field("restarted", user[3], want.restarted);
         compare_field("entry_index", data[4:0], want.index);
         compare_field("entry_first", data[20:5], want.first);
         compare_field("entry_last", data[36:21], want.last);
         compare_field("received", data[68:37], want.received);
         compare_field("gaps", data[100:69], want.gaps);
         compare_field("dups", data[132:101], want.dups);
      endtask
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata = '0;     // [15:0] source_addr, [31:16] seq_num
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [135:0]  rsp_tdata;          // [4:0] index, [20:5] first, [36:21] last,
                                      // [68:37] received, [100:69] gaps, [132:101] dups
   logic [3:0]    rsp_tuser;          // [2:0] status, [3] restarted
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [3:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   sequence_tracker_model tracker = new();
   logic [15:0] pool[TABLE_ENTRIES];
   bit          steady = 1'b0;
   int          hold_off = 0;

   per_source_sequence_tracker dut (.*);

   always #4 clock = ~clock;

   function automatic bit roll_idle();
      return !steady && ($urandom_range(99) < 32);
   endfunction

   function automatic bit in_pool(logic [15:0] v);
      foreach (pool[i]) if (pool[i] == v) return 1'b1;
      return 1'b0;
   endfunction

   task automatic send_packet(input logic [15:0] src, input logic [15:0] seq);
      while (roll_idle()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {seq, src};
      do @(posedge clock); while (!req_tready);
      tracker.note_packet(src, seq);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      tracker.set_register(idx, value);
      // read back through the same select
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {16'h0000, value})
         tracker.report_mismatch($sformatf("register %0d read %h expected %h",
                                           idx, csr_prdata, value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_random();
      int          k;
      int          pick;
      logic [15:0] src;
      logic [15:0] last;
      logic [15:0] seq;
      pick = $urandom_range(99);
      if (pick < 5) begin
         do src = 16'($urandom); while (in_pool(src));
         send_packet(src, 16'($urandom));
      end else begin
         k = ($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(TABLE_ENTRIES - 1);
         // slot k holds pool[k]: the table was filled in pool order
         last = tracker.last_of[k];
         pick = $urandom_range(99);
         if (pick < 60)      seq = last + 16'd1;
         else if (pick < 72) seq = last + 16'($urandom_range(40, 2));
         else if (pick < 82) seq = last - 16'($urandom_range(5));
         else if (pick < 92) seq = 16'($urandom_range(4));
         else                seq = 16'($urandom);
         send_packet(pool[k], seq);
      end
   endtask

   task automatic wait_drained();
      while (tracker.expected_entries.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input logic [15:0] min_rx, input logic [15:0] low,
                            input logic [15:0] high, input int count);
      wait_drained();
      write_register(REG_MIN_RECEIVED, min_rx);
      write_register(REG_LOW_SEQ, low);
      write_register(REG_HIGH_LAST, high);
      repeat (count) send_random();
      req_tvalid <= 1'b0;
   endtask

   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) tracker.check_result(rsp_tdata, rsp_tuser);
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            hold_off--;
         end else begin
            rsp_tready <= !roll_idle();
         end
      end
   end

   initial begin : watchdog
      #2000000;
      $display("** per_source_sequence_tracker: FAILED **");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] cand;
      foreach (pool[i]) pool[i] = 16'h0000;
      pool[1] = 16'hFFFF;
      for (int k = 2; k < TABLE_ENTRIES; k++) begin
         // draw a fresh address that no earlier pool entry holds
         do cand = 16'($urandom); while (cand == 16'h0000 || cand == 16'hFFFF ||
                                         in_pool(cand));
         pool[k] = cand;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first, in order, gap, duplicate and old on the lowest address
      send_packet(pool[0], 16'd0);
      send_packet(pool[0], 16'd1);
      send_packet(pool[0], 16'd5);
      send_packet(pool[0], 16'd5);
      send_packet(pool[0], 16'd2);
      // wrap of the sequence on the highest address, then the widest skip
      send_packet(pool[1], 16'hFFFF);
      send_packet(pool[1], 16'h0000);
      send_packet(pool[1], 16'hFFFF);
      send_packet(pool[1], 16'hFFFF);
      // sender restart to sequence zero clears the entry, next packet counts as first
      send_packet(pool[2], 16'd200);
      for (int i = 1; i <= 11; i++) send_packet(pool[2], 16'(200 + i));
      send_packet(pool[2], 16'd0);
      send_packet(pool[2], 16'd7);

      // fill the table, then one stranger finds it full
      for (int k = 0; k < TABLE_ENTRIES; k++) send_packet(pool[k], 16'($urandom));
      send_random_stranger: begin
         logic [15:0] src;
         do src = 16'($urandom); while (in_pool(src));
         send_packet(src, 16'($urandom));
      end
      repeat (120) send_random();
      req_tvalid <= 1'b0;

      run_phase(16'd0, 16'd0, 16'd0, 130);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 130);
      hold_off = 400;
      run_phase(16'd0, 16'hFFFF, 16'd0, 130);
      run_phase(16'($urandom_range(20)), 16'($urandom_range(50, 1)),
                16'($urandom_range(500)), 130);
      steady = 1'b1;
      hold_off = 300;
      run_phase(RST_MIN_RECEIVED, RST_LOW_SEQ, RST_HIGH_LAST, 130);

      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("** per_source_sequence_tracker: PASSED **");
      else
         $display("** per_source_sequence_tracker: FAILED **");
      $finish;
   end

endmodule
